// ===== hw/rtl/i2cm_pkg.sv =====
// i2cm_pkg: shared types and constants for the I2C master byte engine.
// Holds command codes, register indexes, reset values and the tick/result structs.
// No dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

	// Command codes carried by a tick
	localparam logic [2:0] CMD_NONE       = 3'd0;
	localparam logic [2:0] CMD_START      = 3'd1;
	localparam logic [2:0] CMD_STOP       = 3'd2;
	localparam logic [2:0] CMD_WRITE      = 3'd3;
	localparam logic [2:0] CMD_READ       = 3'd4;
	localparam logic [2:0] CMD_START_ADDR = 3'd5;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DELAY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_DELAY  = 1'b1;

	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_DATA_W-1:0] SHORT_DELAY_RST = 16'd5;
	localparam logic [CFG_DATA_W-1:0] LONG_DELAY_RST  = 16'd10;

	// One input tick
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] byte_to_send;
		logic [6:0] target_address;
		logic       read_direction;
		logic       send_ack;
		logic       sda_sample;
	} tick_t;

	// One result item
	typedef struct packed {
		logic       scl_level;
		logic       scl_drive;
		logic       sda_level;
		logic       sda_drive;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       ack_error;
	} res_t;

endpackage

// ===== hw/rtl/i2cm_seq.sv =====
// i2cm_seq: bus sequencer state and its next-state logic, one tick per enable.
// Produces the result of each tick from the updated state.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_seq
	import i2cm_pkg::*;
#(
	parameter int unsigned DELAY_COUNTER_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  tick_t                 tick,
	input  logic [CFG_DATA_W-1:0] short_delay,
	input  logic [CFG_DATA_W-1:0] long_delay,
	output res_t                  res
);

	localparam int unsigned DCW = DELAY_COUNTER_WIDTH;

	typedef enum logic [19:0] {
		PH_IDLE = 20'h00001,
		PH_S0   = 20'h00002,
		PH_S1   = 20'h00004,
		PH_S2   = 20'h00008,
		PH_S3   = 20'h00010,
		PH_W0   = 20'h00020,
		PH_W1   = 20'h00040,
		PH_W2   = 20'h00080,
		PH_W3   = 20'h00100,
		PH_W4   = 20'h00200,
		PH_W5   = 20'h00400,
		PH_R0   = 20'h00800,
		PH_R1   = 20'h01000,
		PH_R2   = 20'h02000,
		PH_R3   = 20'h04000,
		PH_R4   = 20'h08000,
		PH_P0   = 20'h10000,
		PH_P1   = 20'h20000,
		PH_P2   = 20'h40000,
		PH_P3   = 20'h80000
	} phase_t;

	typedef struct packed {
		logic scl_lvl;
		logic scl_drv;
		logic sda_lvl;
		logic sda_drv;
	} line_t;

	localparam line_t LINES_RELEASED = '{scl_lvl: 1'b1, scl_drv: 1'b0,
		sda_lvl: 1'b1, sda_drv: 1'b0};

	phase_t          phase_q, phase_d, tgt;
	logic [2:0]      cmd_q, cmd_d;
	logic [2:0]      bit_q, bit_d;
	logic [7:0]      shift_q, shift_d;
	logic [DCW-1:0]  delay_q, delay_d, delay_dec;
	logic            ackc_q, ackc_d;
	logic            noack_q, noack_d;
	logic [7:0]      rxb_q, rxb_d;
	line_t           line_q, line_d;
	logic            go, finish, is_long, cmd_ok;

	// Delay reload: zero counts as one, saturate to the counter range
	function automatic logic [DCW-1:0] load_val(input logic [CFG_DATA_W-1:0] d);
		logic [31:0] d32;
		logic [32:0] max33;
		d32 = 32'(d);
		if (d32 == 32'd0)
			d32 = 32'd1;
		max33 = (33'd1 << DCW) - 33'd1;
		if ({1'b0, d32} > max33)
			return '1;
		else
			return d32[DCW-1:0];
	endfunction

	assign cmd_ok = (tick.command >= CMD_START) && (tick.command <= CMD_START_ADDR);
	assign delay_dec = (delay_q == '0) ? '0 : delay_q - DCW'(1);

	// Next state for one tick
	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		delay_d = delay_q;
		ackc_d  = ackc_q;
		noack_d = noack_q;
		rxb_d   = rxb_q;
		line_d  = line_q;
		go      = 1'b0;
		finish  = 1'b0;
		is_long = 1'b0;
		tgt     = PH_IDLE;

		if (phase_q == PH_IDLE) begin
			if (cmd_ok) begin
				cmd_d  = tick.command;
				bit_d  = 3'd0;
				ackc_d = tick.send_ack;
				case (tick.command)
					CMD_WRITE:      shift_d = tick.byte_to_send;
					CMD_START_ADDR: shift_d = {tick.target_address, tick.read_direction};
					default:        shift_d = 8'd0;
				endcase
				go = 1'b1;
				case (tick.command)
					CMD_START, CMD_START_ADDR: tgt = PH_S0;
					CMD_STOP:                  tgt = PH_P0;
					CMD_WRITE:                 tgt = PH_W0;
					default:                   tgt = PH_R0;
				endcase
			end
		end else begin
			delay_d = delay_dec;
			if (delay_dec == '0) begin
				unique case (phase_q)
					PH_S0: begin go = 1'b1; tgt = PH_S1; end
					PH_S1: begin go = 1'b1; tgt = PH_S2; end
					PH_S2: begin go = 1'b1; tgt = PH_S3; end
					PH_S3: begin
						if (cmd_q == CMD_START_ADDR) begin
							bit_d = 3'd0;
							go    = 1'b1;
							tgt   = PH_W0;
						end else begin
							finish = 1'b1;
						end
					end
					PH_W0: begin go = 1'b1; tgt = PH_W1; end
					PH_W1: begin go = 1'b1; tgt = PH_W2; end
					PH_W2: begin
						go = 1'b1;
						if (bit_q != 3'd7) begin
							bit_d = bit_q + 3'd1;
							tgt   = PH_W0;
						end else begin
							tgt = PH_W3;
						end
					end
					PH_W3: begin go = 1'b1; tgt = PH_W4; end
					PH_W4: begin
						noack_d = tick.sda_sample;
						go      = 1'b1;
						tgt     = PH_W5;
					end
					PH_R0: begin go = 1'b1; tgt = PH_R1; end
					PH_R1: begin
						shift_d = {shift_q[6:0], tick.sda_sample};
						go      = 1'b1;
						tgt     = PH_R2;
					end
					PH_R2: begin
						go = 1'b1;
						if (bit_q != 3'd7) begin
							bit_d = bit_q + 3'd1;
							tgt   = PH_R0;
						end else begin
							tgt = PH_R3;
						end
					end
					PH_R3: begin go = 1'b1; tgt = PH_R4; end
					PH_R4: begin
						rxb_d  = shift_q;
						finish = 1'b1;
					end
					PH_P0: begin go = 1'b1; tgt = PH_P1; end
					PH_P1: begin go = 1'b1; tgt = PH_P2; end
					PH_P2: begin go = 1'b1; tgt = PH_P3; end
					// end of stop, end of write
					default: finish = 1'b1;
				endcase
			end
		end

		// Line change of the step being entered
		if (go) begin
			phase_d = tgt;
			unique case (tgt)
				PH_S0: begin line_d.sda_drv = 1'b1; line_d.sda_lvl = 1'b1; end
				PH_S1: begin line_d.scl_drv = 1'b1; line_d.scl_lvl = 1'b1; end
				PH_S2: begin line_d.sda_drv = 1'b1; line_d.sda_lvl = 1'b0; end
				PH_S3: begin line_d.scl_drv = 1'b1; line_d.scl_lvl = 1'b0; end
				PH_W0: begin
					line_d.sda_drv = 1'b1;
					line_d.sda_lvl = shift_d[~bit_d];
				end
				PH_W1, PH_W4, PH_R1: begin
					line_d.scl_drv = 1'b1;
					line_d.scl_lvl = 1'b1;
					is_long        = 1'b1;
				end
				PH_W2, PH_W5, PH_R2: begin
					line_d.scl_drv = 1'b1;
					line_d.scl_lvl = 1'b0;
				end
				PH_W3: begin line_d.sda_drv = 1'b0; line_d.sda_lvl = 1'b1; end
				PH_R0, PH_R4: begin
					line_d.sda_drv = 1'b0;
					line_d.sda_lvl = 1'b1;
					line_d.scl_drv = 1'b1;
					line_d.scl_lvl = 1'b0;
				end
				PH_R3: begin
					line_d.sda_drv = 1'b1;
					line_d.sda_lvl = ~ackc_q;
					line_d.scl_drv = 1'b1;
					line_d.scl_lvl = 1'b1;
					is_long        = 1'b1;
				end
				PH_P0: begin
					line_d.sda_drv = 1'b1;
					line_d.sda_lvl = 1'b0;
					line_d.scl_drv = 1'b1;
					line_d.scl_lvl = 1'b0;
				end
				PH_P1: begin line_d.scl_drv = 1'b1; line_d.scl_lvl = 1'b1; end
				PH_P2: begin line_d.sda_drv = 1'b1; line_d.sda_lvl = 1'b1; end
				PH_P3: line_d = LINES_RELEASED;
				default: line_d = line_q;
			endcase
			delay_d = is_long ? load_val(long_delay) : load_val(short_delay);
		end

		if (finish) begin
			phase_d = PH_IDLE;
			delay_d = '0;
		end
	end

	// State registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q   <= CMD_NONE;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			delay_q <= '0;
			ackc_q  <= 1'b0;
			noack_q <= 1'b0;
			rxb_q   <= 8'd0;
			line_q  <= LINES_RELEASED;
		end else if (en) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			delay_q <= delay_d;
			ackc_q  <= ackc_d;
			noack_q <= noack_d;
			rxb_q   <= rxb_d;
			line_q  <= line_d;
		end
	end

	// Result of this tick
	assign res.scl_level = line_d.scl_lvl;
	assign res.scl_drive = line_d.scl_drv;
	assign res.sda_level = line_d.sda_lvl;
	assign res.sda_drive = line_d.sda_drv;
	assign res.busy      = (phase_d != PH_IDLE);
	assign res.done      = finish;
	assign res.read_data = rxb_d;
	assign res.ack_error = noack_d;

	// Checks
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("sequencer phase not one-hot");

	a_delay_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (delay_q != '0))
		else $error("active step with empty delay counter");

	a_idle_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(en && phase_q == PH_IDLE && !cmd_ok) |=> (phase_q == PH_IDLE))
		else $error("left idle without a command");

endmodule

// ===== hw/rtl/i2c_master_byte_engine.sv =====
// Tick-driven I2C master: each accepted tick advances the bus sequencer by one step
// of its delay count and yields one result item with line levels and status.
// A tick is accepted each clock cycle unless tick_stall is high; its result goes to
// the output register, or to a one-entry skid stage behind it when the output
// register is held by a result-side stall, so tick_stall rises only once both are
// full. The rate is set by the single sequencer update per tick. Delay registers are
// written through a cfg port that is always ready. Depends on i2cm_pkg, i2cm_seq.
`timescale 1ns / 1ps

module i2c_master_byte_engine
	import i2cm_pkg::*;
#(
	parameter int unsigned DELAY_COUNTER_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// tick channel
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  logic [2:0]            command,
	input  logic [7:0]            byte_to_send,
	input  logic [6:0]            target_address,
	input  logic                  read_direction,
	input  logic                  send_ack,
	input  logic                  sda_sample,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  scl_level,
	output logic                  scl_drive,
	output logic                  sda_level,
	output logic                  sda_drive,
	output logic                  busy_res,
	output logic                  done_res,
	output logic [7:0]            read_data,
	output logic                  ack_error,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CFG_DATA_W-1:0] short_delay_q, long_delay_q;
	tick_t tick;
	res_t  seq_res, out_q, skid_q;
	logic  out_valid_q, skid_valid_q;
	logic  tick_fire, res_fire;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_delay_q <= SHORT_DELAY_RST;
			long_delay_q  <= LONG_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHORT_DELAY: short_delay_q <= cfg_data;
				CFG_LONG_DELAY:  long_delay_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshakes
	assign tick_stall = skid_valid_q;
	assign tick_fire  = tick_valid && !tick_stall;
	assign res_fire   = out_valid_q && !res_stall;

	assign tick = '{command: command, byte_to_send: byte_to_send,
		target_address: target_address, read_direction: read_direction,
		send_ack: send_ack, sda_sample: sda_sample};

	i2cm_seq #(
		.DELAY_COUNTER_WIDTH(DELAY_COUNTER_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (tick_fire),
		.tick       (tick),
		.short_delay(short_delay_q),
		.long_delay (long_delay_q),
		.res        (seq_res)
	);

	// Output register and skid stage: valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (res_fire)
					skid_valid_q <= 1'b0;
			end else if (tick_fire) begin
				if (!out_valid_q || res_fire)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (res_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register and skid stage: payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (res_fire)
				out_q <= skid_q;
		end else if (tick_fire) begin
			if (!out_valid_q || res_fire)
				out_q <= seq_res;
			else
				skid_q <= seq_res;
		end
	end

	assign res_valid = out_valid_q;
	assign scl_level = out_q.scl_level;
	assign scl_drive = out_q.scl_drive;
	assign sda_level = out_q.sda_level;
	assign sda_drive = out_q.sda_drive;
	assign busy_res  = out_q.busy;
	assign done_res  = out_q.done;
	assign read_data = out_q.read_data;
	assign ack_error = out_q.ack_error;

	// Checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry without output entry");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !res_stall) |=> !skid_valid_q)
		else $error("skid entry not drained");

	a_skid_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_stall && !skid_valid_q && tick_valid) |=> skid_valid_q)
		else $error("tick taken during stall not held in skid");

endmodule
